>>> src/qevb_pkg.sv
// Shared types, command codes and helpers for the quadrature encoder volume bank.
package qevb_pkg;

   // Field widths
   localparam int CMD_W     = 3;
   localparam int CHAN_W    = 2;
   localparam int LEVEL_W   = 7;
   localparam int HOST_W    = 10;
   localparam int BAR_W     = 10;
   localparam int LED_CHANS = 4;
   localparam int LED_W     = BAR_W * LED_CHANS;
   localparam int DIRTY_W   = 4;

   // Defaults and limits
   localparam int CHANNELS_DEFAULT = 4;
   localparam logic [LEVEL_W-1:0] LEVEL_MAX        = 7'd100;
   localparam logic [LEVEL_W-1:0] CLICK_RATE_RESET = 7'd2;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_A_EDGE      = 3'd0;
   localparam logic [CMD_W-1:0] CMD_B_EDGE      = 3'd1;
   localparam logic [CMD_W-1:0] CMD_SWITCH      = 3'd2;
   localparam logic [CMD_W-1:0] CMD_SET_LEVEL   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CLEAR_DIRTY = 3'd4;

   // 1023/100 scaled by 2^24, taken slightly high; exact for every level 0..100
   localparam int HOST_SHIFT = 24;
   localparam logic [27:0] HOST_MULT = 28'd171631779;

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [CHAN_W-1:0]  channel;
      logic               pin_a;
      logic               pin_b;
      logic [LEVEL_W-1:0] new_level;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0]  out_channel;
      logic [LEVEL_W-1:0] level;
      logic               is_muted;
      logic [LEVEL_W-1:0] effective_level;
      logic [HOST_W-1:0]  host_value;
      logic [BAR_W-1:0]   bar_segments;
      logic [LED_W-1:0]   led_word;
      logic               changed;
      logic [DIRTY_W-1:0] dirty_mask;
   } rsp_type;

   // Thermometer bar: ceil(level/10) low bits set; (x*205)>>11 is x/10 for x < 1029
   function automatic logic [BAR_W-1:0] bar_of(input logic [LEVEL_W-1:0] eff);
      logic [7:0]  sum;
      logic [15:0] prod;
      logic [3:0]  segs;
      logic [BAR_W-1:0] bar;
      sum  = {1'b0, eff} + 8'd9;
      prod = 16'(sum) * 16'd205;
      segs = prod[14:11];
      for (int i = 0; i < BAR_W; i++) begin
         bar[i] = (4'(i) < segs);
      end
      return bar;
   endfunction

   // Host scale 1023*eff/100 by reciprocal multiply
   function automatic logic [HOST_W-1:0] host_of(input logic [LEVEL_W-1:0] eff);
      logic [34:0] prod;
      prod = 35'(eff) * 35'(HOST_MULT);
      return prod[HOST_SHIFT +: HOST_W];
   endfunction

endpackage

>>> src/quad_encoder_volume_bank_top.sv
// Top level of the quadrature encoder volume bank: event register, update logic, result register.
//
//   channel   direction  handshake                  payload
//   req_      in         req_valid / req_ready      req_data  (qevb_pkg::req_type)
//   rsp_      out        rsp_valid / rsp_ready      rsp_data  (qevb_pkg::rsp_type)
//   csr_      in         csr_we (no wait)           csr_wdata (click rate)
//
// One event per cycle sustained while rsp_ready stays high; a req beat reaches rsp_valid via
// an event register, then a single pass that reads, updates and writes the channel
// state and loads the result register. Reset (synchronous, active high) zeroes all
// levels, mute and dirty bits and sets the click rate to 2. A stalled result holds
// the result register; the event register still takes one more beat before req_ready drops.
module quad_encoder_volume_bank_top #(
   parameter int CHANNELS = qevb_pkg::CHANNELS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  qevb_pkg::req_type          req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output qevb_pkg::rsp_type          rsp_data,
   input  logic                       csr_we,
   input  logic [qevb_pkg::LEVEL_W-1:0] csr_wdata
);
   import qevb_pkg::*;

   localparam int StoreN = (CHANNELS < LED_CHANS) ? LED_CHANS : CHANNELS;

   // Registers
   logic               in_valid_ff;
   req_type            in_data_ff;
   logic               out_valid_ff;
   rsp_type            out_data_ff, out_data_in;
   logic [LEVEL_W-1:0] click_rate_ff;
   logic [LEVEL_W-1:0] levels_ff [CHANNELS];
   logic [LEVEL_W-1:0] levels_in [CHANNELS];
   logic [CHANNELS-1:0] mute_ff, mute_in;
   logic [DIRTY_W-1:0] dirty_ff, dirty_in;

   logic               advance;
   logic               exists;
   logic [LEVEL_W-1:0] old_level, new_value;
   logic               old_mute, new_mute;
   logic               changed;
   logic [LEVEL_W:0]   sum_up;
   logic               edge_ok;
   logic [LEVEL_W-1:0] eff_lane [StoreN];
   logic [LEVEL_W-1:0] sel_level, sel_eff;
   logic               sel_mute;
   logic [LED_W-1:0]   led;

   // Handshake: advance the event into the result register when it is free
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // Read-modify-write of the addressed channel
   always_comb begin
      exists    = int'(in_data_ff.channel) < CHANNELS;
      old_level = '0;
      old_mute  = 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
         if (int'(in_data_ff.channel) == c) begin
            old_level = levels_ff[c];
            old_mute  = mute_ff[c];
         end
      end

      edge_ok   = in_data_ff.pin_a != in_data_ff.pin_b;
      sum_up    = {1'b0, old_level} + {1'b0, click_rate_ff};
      new_value = old_level;
      new_mute  = old_mute;
      dirty_in  = dirty_ff;
      changed   = 1'b0;

      case (in_data_ff.command)
         CMD_A_EDGE: begin
            if (edge_ok) begin
               new_value = (sum_up > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : sum_up[LEVEL_W-1:0];
            end
         end
         CMD_B_EDGE: begin
            if (edge_ok) begin
               new_value = (old_level > click_rate_ff) ? old_level - click_rate_ff : '0;
            end
         end
         CMD_SWITCH: begin
            new_mute = !old_mute;
            changed  = 1'b1;
         end
         CMD_SET_LEVEL: begin
            new_value = (in_data_ff.new_level > LEVEL_MAX) ? LEVEL_MAX : in_data_ff.new_level;
            dirty_in[in_data_ff.channel] = 1'b1;
         end
         CMD_CLEAR_DIRTY: begin
            dirty_in[in_data_ff.channel] = 1'b0;
         end
         default: begin
         end
      endcase

      if (new_value != old_level) begin
         changed = 1'b1;
      end
      if (!exists) begin
         changed  = 1'b0;
         dirty_in = dirty_ff;
      end else if (changed) begin
         dirty_in[in_data_ff.channel] = 1'b1;
      end

      // Next state per lane
      for (int c = 0; c < CHANNELS; c++) begin
         if (exists && int'(in_data_ff.channel) == c) begin
            levels_in[c] = new_value;
            mute_in[c]   = new_mute;
         end else begin
            levels_in[c] = levels_ff[c];
            mute_in[c]   = mute_ff[c];
         end
      end

      for (int c = 0; c < StoreN; c++) begin
         eff_lane[c] = '0;
      end
      for (int c = 0; c < CHANNELS; c++) begin
         eff_lane[c] = mute_in[c] ? '0 : levels_in[c];
      end

      // Pack the LED word, channel 0 at the top
      for (int c = 0; c < LED_CHANS; c++) begin
         led[BAR_W*(LED_CHANS-1-c) +: BAR_W] = bar_of(eff_lane[c]);
      end

      sel_level = exists ? new_value : '0;
      sel_mute  = exists ? new_mute : 1'b0;
      sel_eff   = sel_mute ? '0 : sel_level;

      out_data_in.out_channel     = in_data_ff.channel;
      out_data_in.level           = sel_level;
      out_data_in.is_muted        = sel_mute;
      out_data_in.effective_level = sel_eff;
      out_data_in.host_value      = host_of(sel_eff);
      out_data_in.bar_segments    = exists ? bar_of(sel_eff) : '0;
      out_data_in.led_word        = led;
      out_data_in.changed         = changed;
      out_data_in.dirty_mask      = dirty_in;
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         click_rate_ff <= CLICK_RATE_RESET;
         mute_ff       <= '0;
         dirty_ff      <= '0;
         for (int c = 0; c < CHANNELS; c++) begin
            levels_ff[c] <= '0;
         end
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            mute_ff      <= mute_in;
            dirty_ff     <= dirty_in;
            for (int c = 0; c < CHANNELS; c++) begin
               levels_ff[c] <= levels_in[c];
            end
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            click_rate_ff <= csr_wdata;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

`ifndef SYNTHESIS
   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");
   a_changed_marks_dirty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.changed) |-> rsp_data.dirty_mask[rsp_data.out_channel])
      else $error("changed result without dirty bit");
   a_level_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.level <= LEVEL_MAX && rsp_data.effective_level <= rsp_data.level))
      else $error("level outside clamp");
   a_ready_only_on_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("input stalled without output stall");
`endif

endmodule

>>> tb/sv/qevb_volume_checker.sv
// Beat monitor, state predictor and result comparison for the encoder volume bank.
`timescale 1ns / 1ps

module qevb_volume_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  qevb_pkg::req_type             req_data,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  qevb_pkg::rsp_type             rsp_data,
   input  logic                          csr_we,
   input  logic [qevb_pkg::LEVEL_W-1:0]  csr_wdata,
   output int unsigned                   outstanding,
   output int unsigned                   mismatches
);
   import qevb_pkg::*;

   localparam int HOST_FULL = 1023;
   localparam int SEG_STEP  = 10;

   // Predicted channel state and click rate
   logic [LEVEL_W-1:0] chan_level [LED_CHANS];
   logic               chan_muted [LED_CHANS];
   logic [DIRTY_W-1:0] dirty_flags;
   logic [LEVEL_W-1:0] click_rate;

   rsp_type            pending_results [$];
   rsp_type            want;

   // Thermometer bar: one segment per started step of ten, ten at most
   function automatic logic [BAR_W-1:0] segment_bar(input int eff);
      int lit;
      lit = (eff + SEG_STEP - 1) / SEG_STEP;
      if (lit > BAR_W) lit = BAR_W;
      return BAR_W'((64'd1 << lit) - 64'd1);
   endfunction

   // Apply one event to the predicted state and build the result it reports
   function automatic rsp_type volume_update(input req_type ev);
      rsp_type res;
      int      cur;
      int      nxt;
      int      rate;
      int      eff;
      logic    hit;
      cur  = int'(chan_level[ev.channel]);
      rate = int'(click_rate);
      nxt  = cur;
      hit  = 1'b0;
      case (ev.command)
         CMD_A_EDGE: begin
            if (ev.pin_a != ev.pin_b)
               nxt = (cur + rate > int'(LEVEL_MAX)) ? int'(LEVEL_MAX) : cur + rate;
         end
         CMD_B_EDGE: begin
            if (ev.pin_a != ev.pin_b) nxt = (cur > rate) ? cur - rate : 0;
         end
         CMD_SWITCH: begin
            chan_muted[ev.channel] = !chan_muted[ev.channel];
            hit = 1'b1;
         end
         CMD_SET_LEVEL: begin
            nxt = (ev.new_level > LEVEL_MAX) ? int'(LEVEL_MAX) : int'(ev.new_level);
            dirty_flags[ev.channel] = 1'b1;
         end
         CMD_CLEAR_DIRTY: begin
            dirty_flags[ev.channel] = 1'b0;
         end
         default: begin
         end
      endcase
      if (nxt != cur) begin
         chan_level[ev.channel] = LEVEL_W'(nxt);
         hit = 1'b1;
      end
      if (hit) dirty_flags[ev.channel] = 1'b1;

      res.out_channel     = ev.channel;
      res.level           = chan_level[ev.channel];
      res.is_muted        = chan_muted[ev.channel];
      res.effective_level = res.is_muted ? '0 : res.level;
      eff                 = int'(res.effective_level);
      res.host_value      = HOST_W'((HOST_FULL * eff) / int'(LEVEL_MAX));
      res.bar_segments    = segment_bar(eff);
      res.led_word        = '0;
      for (int c = 0; c < LED_CHANS; c++) begin
         res.led_word[BAR_W*(LED_CHANS-1-c) +: BAR_W] =
            segment_bar(chan_muted[c] ? 0 : int'(chan_level[c]));
      end
      res.changed    = hit;
      res.dirty_mask = dirty_flags;
      return res;
   endfunction

   task automatic compare_field(input string name, input longint unsigned exp_val,
                                input longint unsigned act_val);
      if (exp_val != act_val) begin
         $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
         mismatches++;
      end
   endtask

   // Track config writes, check result beats, predict on request beats
   always @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < LED_CHANS; c++) begin
            chan_level[c] = '0;
            chan_muted[c] = 1'b0;
         end
         dirty_flags = '0;
         click_rate  = CLICK_RATE_RESET;
         pending_results.delete();
      end else begin
         if (csr_we) click_rate = csr_wdata;
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               $error("result beat with no expectation pending");
               mismatches++;
            end else begin
               want = pending_results.pop_front();
               compare_field("out_channel", want.out_channel, rsp_data.out_channel);
               compare_field("level", want.level, rsp_data.level);
               compare_field("is_muted", want.is_muted, rsp_data.is_muted);
               compare_field("effective_level", want.effective_level,
                             rsp_data.effective_level);
               compare_field("host_value", want.host_value, rsp_data.host_value);
               compare_field("bar_segments", want.bar_segments, rsp_data.bar_segments);
               compare_field("led_word", want.led_word, rsp_data.led_word);
               compare_field("changed", want.changed, rsp_data.changed);
               compare_field("dirty_mask", want.dirty_mask, rsp_data.dirty_mask);
            end
         end
         if (req_valid && req_ready) pending_results.push_back(volume_update(req_data));
      end
      outstanding <= pending_results.size();
   end

endmodule

>>> tb/sv/tb_quad_encoder_volume_bank_top.sv
// Stimulus, handshake pacing and verdict for the encoder volume bank.
`timescale 1ns / 1ps

module tb_quad_encoder_volume_bank_top;
   import qevb_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int          DRAIN_CYCLES = 8;
   localparam int          PHASES       = 6;
   localparam int          PHASE_BEATS  = 256;
   localparam logic [CMD_W-1:0] CMD_RSVD_5 = 3'd5;
   localparam logic [CMD_W-1:0] CMD_RSVD_6 = 3'd6;
   localparam logic [CMD_W-1:0] CMD_RSVD_7 = 3'd7;

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   req_type            req_data  = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   rsp_type            rsp_data;
   logic               csr_we    = 1'b0;
   logic [LEVEL_W-1:0] csr_wdata = '0;

   int unsigned outstanding;
   int unsigned mismatches;
   int unsigned cycle_count = 0;
   bit          req_gaps    = 1'b0;
   bit          rsp_stalls  = 1'b0;

   quad_encoder_volume_bank_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   qevb_volume_checker u_volume_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .outstanding (outstanding),
      .mismatches  (mismatches)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_quad_encoder_volume_bank_top: errors");
         $finish;
      end
   end

   // Result side: stall in random bursts while enabled
   initial begin
      forever begin
         @(posedge clock);
         if (rsp_stalls && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   function automatic req_type make_event(input logic [CMD_W-1:0] cmd,
                                          input logic [CHAN_W-1:0] ch,
                                          input logic a, input logic b,
                                          input logic [LEVEL_W-1:0] lvl);
      req_type ev;
      ev.command   = cmd;
      ev.channel   = ch;
      ev.pin_a     = a;
      ev.pin_b     = b;
      ev.new_level = lvl;
      return ev;
   endfunction

   // Mostly counting edges with random content, some noise and odd commands
   function automatic req_type random_event();
      req_type ev;
      int      pick;
      pick         = $urandom_range(0, 99);
      ev.channel   = CHAN_W'($urandom_range(0, 3));
      ev.pin_a     = 1'($urandom_range(0, 1));
      ev.pin_b     = 1'($urandom_range(0, 1));
      ev.new_level = LEVEL_W'($urandom_range(0, 127));
      if (pick < 35)      ev.command = CMD_A_EDGE;
      else if (pick < 70) ev.command = CMD_B_EDGE;
      else if (pick < 78) ev.command = CMD_SWITCH;
      else if (pick < 88) ev.command = CMD_SET_LEVEL;
      else if (pick < 95) ev.command = CMD_CLEAR_DIRTY;
      else                ev.command = CMD_CLEAR_DIRTY + CMD_W'($urandom_range(1, 3));
      if ((ev.command == CMD_A_EDGE || ev.command == CMD_B_EDGE) &&
          $urandom_range(0, 99) < 85)
         ev.pin_b = !ev.pin_a;
      if (ev.command == CMD_SET_LEVEL && $urandom_range(0, 4) != 0)
         ev.new_level = LEVEL_W'($urandom_range(0, int'(LEVEL_MAX)));
      return ev;
   endfunction

   // Present one beat, with an optional gap before it, and hold until accepted
   task automatic send_event(input req_type ev);
      if (req_gaps && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= ev;
      do @(posedge clock); while (!req_ready);
   endtask

   // Drop valid and wait until every predicted result has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic set_click_rate(input logic [LEVEL_W-1:0] rate);
      csr_we    <= 1'b1;
      csr_wdata <= rate;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic run_random(input int beats, input bit calm);
      for (int i = 0; i < beats; i++) begin
         if (calm) begin
            req_gaps   = 1'b0;
            rsp_stalls = 1'b0;
         end else if (i % 40 == 0) begin
            req_gaps   = $urandom_range(0, 2) != 0;
            rsp_stalls = $urandom_range(0, 2) != 0;
         end
         // Hold off mid-phase until the block has emptied
         if (i == beats / 2) drain_results();
         send_event(random_event());
      end
   endtask

   initial begin
      logic [LEVEL_W-1:0] phase_rate [PHASES];
      phase_rate[0] = 7'd1;
      phase_rate[1] = LEVEL_MAX;
      phase_rate[2] = 7'd127;
      phase_rate[3] = 7'd0;
      phase_rate[4] = LEVEL_W'($urandom_range(1, 100));
      phase_rate[5] = LEVEL_W'($urandom_range(1, 100));

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed beats at the reset click rate
      req_gaps   = 1'b1;
      rsp_stalls = 1'b1;
      send_event(make_event(CMD_B_EDGE,      2'd0, 1'b1, 1'b0, 7'd0));   // floor at zero
      send_event(make_event(CMD_A_EDGE,      2'd0, 1'b1, 1'b1, 7'd0));   // lines equal
      send_event(make_event(CMD_A_EDGE,      2'd0, 1'b0, 1'b1, 7'd0));
      send_event(make_event(CMD_A_EDGE,      2'd0, 1'b1, 1'b0, 7'd0));
      send_event(make_event(CMD_B_EDGE,      2'd0, 1'b0, 1'b0, 7'd0));   // lines equal
      send_event(make_event(CMD_SET_LEVEL,   2'd1, 1'b0, 1'b0, 7'd127)); // saturate
      send_event(make_event(CMD_A_EDGE,      2'd1, 1'b1, 1'b0, 7'd0));   // ceiling
      send_event(make_event(CMD_SET_LEVEL,   2'd1, 1'b1, 1'b1, LEVEL_MAX));
      send_event(make_event(CMD_SWITCH,      2'd1, 1'b0, 1'b0, 7'd0));
      send_event(make_event(CMD_B_EDGE,      2'd1, 1'b0, 1'b1, 7'd0));   // step while muted
      send_event(make_event(CMD_SWITCH,      2'd1, 1'b1, 1'b1, 7'd0));
      send_event(make_event(CMD_CLEAR_DIRTY, 2'd1, 1'b0, 1'b0, 7'd0));
      send_event(make_event(CMD_CLEAR_DIRTY, 2'd0, 1'b0, 1'b0, 7'd0));
      send_event(make_event(CMD_RSVD_5,      2'd2, 1'b1, 1'b1, 7'd127));
      send_event(make_event(CMD_RSVD_6,      2'd3, 1'b1, 1'b0, 7'd64));
      send_event(make_event(CMD_RSVD_7,      2'd2, 1'b0, 1'b1, 7'd1));
      send_event(make_event(CMD_SET_LEVEL,   2'd3, 1'b0, 1'b0, 7'd0));   // same level
      send_event(make_event(CMD_SET_LEVEL,   2'd2, 1'b0, 1'b0, 7'd55));
      send_event(make_event(CMD_SWITCH,      2'd2, 1'b0, 1'b0, 7'd0));
      send_event(make_event(CMD_SET_LEVEL,   2'd3, 1'b0, 1'b0, 7'd101));
      send_event(make_event(CMD_CLEAR_DIRTY, 2'd2, 1'b0, 1'b0, 7'd0));
      send_event(make_event(CMD_CLEAR_DIRTY, 2'd3, 1'b0, 1'b0, 7'd0));
      send_event(make_event(CMD_CLEAR_DIRTY, 2'd2, 1'b0, 1'b0, 7'd0));   // already clear
      send_event(make_event(CMD_B_EDGE,      2'd3, 1'b1, 1'b0, 7'd0));
      drain_results();

      // Random phases, one click rate each; the last runs without request gaps or result stalls
      for (int p = 0; p < PHASES; p++) begin
         set_click_rate(phase_rate[p]);
         run_random(PHASE_BEATS, p == PHASES - 1);
         drain_results();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb_quad_encoder_volume_bank_top: clean");
      end else begin
         $display("tb_quad_encoder_volume_bank_top: errors");
      end
      $finish;
   end

endmodule
